// ===== rtl/bpfr_pkg.sv =====
package bpfr_pkg;

   localparam int MAX_PATTERN = 16;
   localparam int CELL_COUNT  = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;
   localparam int IDX_W       = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
   localparam int FILL_W      = $clog2(CELL_COUNT + 1);
   localparam int PAT_IDX_W   = 4;
   localparam int PAT_W       = 128;
   localparam int COUNT_W     = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIND_LOW,
      CSR_FIND_HIGH,
      CSR_REPLACE_LOW,
      CSR_REPLACE_HIGH,
      CSR_PATTERN_LENGTH,
      CSR_MAX_REPLACEMENTS
   } csr_index_type;

   typedef struct packed {
      logic [PAT_W-1:0]   find;
      logic [PAT_W-1:0]   replace;
      logic [FILL_W-1:0]  len;
      logic [COUNT_W-1:0] max_rep;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic load_replace;
   } cell_ctrl_type;

endpackage

// ===== rtl/bpfr_if.sv =====
interface bpfr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, in_byte, in_last, input ready);
   modport sink (input valid, in_byte, in_last, output ready);
endinterface

interface bpfr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [7:0]                   out_byte;
   logic                         out_last;
   logic [bpfr_pkg::COUNT_W-1:0] replacements_done;
   logic                         short_of_count;

   modport source (output valid, out_byte, out_last, replacements_done, short_of_count,
                   input ready);
   modport sink (input valid, out_byte, out_last, replacements_done, short_of_count,
                 output ready);
endinterface

interface bpfr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [bpfr_pkg::CSR_IDX_W-1:0]  index;
   logic [bpfr_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/byte_pattern_find_replace.sv =====
// Throughput: one item per cycle while the output is taken and no drain is under way; an item
// that fills the window yields one result per cycle. A last item drains the window, up to 16
// results at one per cycle while they are taken, input held meanwhile. The output register
// takes the next result while the current one is taken in the same cycle. Reset (synchronous,
// active high) empties the window, clears the count and loads the register reset values;
// window bytes are not cleared.
module byte_pattern_find_replace (
   input  logic       clock,
   input  logic       reset,
   bpfr_req_if.sink   req_chan,
   bpfr_rsp_if.source rsp_chan,
   bpfr_csr_if.sink   csr_chan
);

   localparam int N = bpfr_pkg::CELL_COUNT;
   localparam int FW = bpfr_pkg::FILL_W;
   localparam int CW = bpfr_pkg::COUNT_W;

   bpfr_pkg::cfg_type       cfg;
   bpfr_pkg::cell_ctrl_type cell_ctrl [N];
   logic [7:0]              cell_data [N];
   logic [7:0]              shift_in [N];
   logic [7:0]              find_byte [N];
   logic [7:0]              replace_byte [N];
   logic [N-1:0]            cell_eq;
   logic [N-1:0]            cell_active;

   logic [FW-1:0] fill_ff;
   logic [FW-1:0] stop_ff;
   logic [FW-1:0] len_ff;
   logic          last_ff;
   logic          short_ff;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_old_ff;

   logic          out_valid_ff;
   logic [7:0]    out_byte_ff;
   logic          out_last_ff;
   logic [CW-1:0] out_count_ff;
   logic          out_short_ff;

   logic                          pend;
   logic                          out_free;
   logic                          emit;
   logic [FW-1:0]                 fill_e;
   logic [FW-1:0]                 fill_s;
   logic [FW-1:0]                 fill_m1;
   logic [bpfr_pkg::IDX_W-1:0]    emit_idx;
   logic                          busy;
   logic                          accept;
   logic                          cmp_en;
   logic                          match;
   logic [CW-1:0]                 base;
   logic                          under;
   logic                          rep;
   logic [CW-1:0]                 cnt_new;
   logic                          short_new;
   logic [FW-1:0]                 stop_new;
   logic                          emit_last;

   bpfr_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   for (genvar i = 0; i < N; i++) begin : g_cell
      bpfr_cell u_cell (
         .clock        (clock),
         .ctrl         (cell_ctrl[i]),
         .shift_in     (shift_in[i]),
         .find_byte    (find_byte[i]),
         .replace_byte (replace_byte[i]),
         .data         (cell_data[i]),
         .eq           (cell_eq[i])
      );
   end

   assign pend     = fill_ff > stop_ff;
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign emit     = pend && out_free;
   assign fill_e   = fill_ff - FW'(emit);
   assign busy     = fill_e > stop_ff;
   assign accept   = req_chan.valid && !busy;
   assign fill_s   = fill_e + FW'(1);
   assign cmp_en   = fill_s >= cfg.len;
   assign fill_m1  = fill_ff - FW'(1);
   assign emit_idx = fill_m1[bpfr_pkg::IDX_W-1:0];

   assign req_chan.ready = !busy;

   always_comb begin
      logic [FW-1:0]                  k;
      logic [bpfr_pkg::PAT_IDX_W-1:0] kb;
      for (int i = 0; i < N; i++) begin
         k              = cfg.len - FW'(1) - FW'(i);
         kb             = k[bpfr_pkg::PAT_IDX_W-1:0];
         cell_active[i] = FW'(i) < cfg.len;
         find_byte[i]   = cfg.find[{kb, 3'b000} +: 8];
         replace_byte[i] = cfg.replace[{kb, 3'b000} +: 8];
         shift_in[i]    = (i == 0) ? req_chan.in_byte : cell_data[(i == 0) ? 0 : i - 1];
      end
   end

   assign match     = cmp_en && (&(cell_eq | ~cell_active));
   assign base      = last_ff ? '0 : cnt_ff;
   assign under     = (cfg.max_rep == '0) || (base < cfg.max_rep);
   assign rep       = accept && match && under;
   assign cnt_new   = base + CW'(rep && (base != {CW{1'b1}}));
   assign short_new = (cfg.max_rep != '0) && (cnt_new < cfg.max_rep);
   assign emit_last = emit && last_ff && (fill_ff == FW'(1));

   always_comb begin
      priority if (req_chan.in_last) begin
         stop_new = '0;
      end else if (cmp_en) begin
         stop_new = cfg.len - FW'(1);
      end else begin
         stop_new = fill_s;
      end
   end

   always_comb begin
      for (int i = 0; i < N; i++) begin
         cell_ctrl[i].shift        = accept;
         cell_ctrl[i].load_replace = rep && cell_active[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         stop_ff      <= '0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         cnt_old_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            fill_ff    <= fill_s;
            stop_ff    <= stop_new;
            last_ff    <= req_chan.in_last;
            cnt_ff     <= cnt_new;
            cnt_old_ff <= base;
         end else begin
            fill_ff <= fill_e;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         len_ff   <= cfg.len;
         short_ff <= short_new;
      end
      if (emit) begin
         out_byte_ff  <= cell_data[emit_idx];
         out_last_ff  <= last_ff && (fill_ff == FW'(1));
         out_count_ff <= (fill_m1 >= len_ff) ? cnt_old_ff : cnt_ff;
         out_short_ff <= last_ff && (fill_ff == FW'(1)) && short_ff;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.out_byte          = out_byte_ff;
   assign rsp_chan.out_last          = out_last_ff;
   assign rsp_chan.replacements_done = out_count_ff;
   assign rsp_chan.short_of_count    = out_short_ff;

   a_fill_above_stop: assert property (@(posedge clock) disable iff (reset)
      fill_ff >= stop_ff)
      else $error("window fill below emission stop");

   a_fill_cap: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= N)
      else $error("window fill beyond cell count");

   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      emit_last |=> fill_ff <= FW'(1))
      else $error("window not empty after final byte");

endmodule

// ===== rtl/bpfr_csr.sv =====
module bpfr_csr (
   input  logic              clock,
   input  logic              reset,
   bpfr_csr_if.sink          csr_chan,
   output bpfr_pkg::cfg_type cfg
);

   logic [bpfr_pkg::CSR_DATA_W-1:0] find_low_ff;
   logic [bpfr_pkg::CSR_DATA_W-1:0] find_high_ff;
   logic [bpfr_pkg::CSR_DATA_W-1:0] replace_low_ff;
   logic [bpfr_pkg::CSR_DATA_W-1:0] replace_high_ff;
   logic [4:0]                      pattern_length_ff;
   logic [bpfr_pkg::COUNT_W-1:0]    max_rep_ff;
   logic [bpfr_pkg::FILL_W-1:0]     eff_len;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         find_low_ff       <= '0;
         find_high_ff      <= '0;
         replace_low_ff    <= '0;
         replace_high_ff   <= '0;
         pattern_length_ff <= 5'd1;
         max_rep_ff        <= '0;
      end else if (csr_chan.valid) begin
         unique case (bpfr_pkg::csr_index_type'(csr_chan.index))
            bpfr_pkg::CSR_FIND_LOW:         find_low_ff       <= csr_chan.data;
            bpfr_pkg::CSR_FIND_HIGH:        find_high_ff      <= csr_chan.data;
            bpfr_pkg::CSR_REPLACE_LOW:      replace_low_ff    <= csr_chan.data;
            bpfr_pkg::CSR_REPLACE_HIGH:     replace_high_ff   <= csr_chan.data;
            bpfr_pkg::CSR_PATTERN_LENGTH:   pattern_length_ff <= csr_chan.data[4:0];
            bpfr_pkg::CSR_MAX_REPLACEMENTS: max_rep_ff        <= csr_chan.data[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      priority if (pattern_length_ff == 5'd0) begin
         eff_len = bpfr_pkg::FILL_W'(1);
      end else if (32'(pattern_length_ff) > bpfr_pkg::CELL_COUNT) begin
         eff_len = bpfr_pkg::FILL_W'(bpfr_pkg::CELL_COUNT);
      end else begin
         eff_len = bpfr_pkg::FILL_W'(pattern_length_ff);
      end
   end

   assign cfg.find    = {find_high_ff, find_low_ff};
   assign cfg.replace = {replace_high_ff, replace_low_ff};
   assign cfg.len     = eff_len;
   assign cfg.max_rep = max_rep_ff;

endmodule

// ===== rtl/bpfr_cell.sv =====
module bpfr_cell (
   input  logic                    clock,
   input  bpfr_pkg::cell_ctrl_type ctrl,
   input  logic [7:0]              shift_in,
   input  logic [7:0]              find_byte,
   input  logic [7:0]              replace_byte,
   output logic [7:0]              data,
   output logic                    eq
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   assign eq      = (shift_in == find_byte);
   assign data_in = ctrl.load_replace ? replace_byte : shift_in;
   assign data    = data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== tb/sv/byte_pattern_find_replace_tb.sv =====
module byte_pattern_find_replace_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_last;
      logic [15:0] done;
      logic        short_flag;
   } scan_out_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_BYTE, ROW_TYPED} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      bpfr_pkg::csr_index_type csr_idx;
      logic [63:0]             csr_data;
      logic [7:0]              in_byte;
      logic                    in_last;
      scan_out_type            want;
   } stim_row_type;

   localparam int DIR_ROWS = 34;

   logic clock = 1'b0;
   logic reset;

   bpfr_req_if req_if ();
   bpfr_rsp_if rsp_if ();
   bpfr_csr_if csr_if ();

   byte_pattern_find_replace u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #1 clock = ~clock;

   // block copy: registers, window and count
   logic [127:0] find_pat;
   logic [127:0] replace_pat;
   logic [4:0]   pat_len;
   logic [15:0]  max_rep;
   logic [7:0]   win_bytes [0:15];
   int           win_fill;
   logic [15:0]  rep_count;

   scan_out_type step_out_q [$];
   scan_out_type scan_out_q [$];
   stim_row_type dir_rows [0:DIR_ROWS-1];

   bit steady       = 1'b0;
   bit hold_request = 1'b0;

   int bytes_sent        = 0;
   int regions_done      = 0;
   int csr_writes        = 0;
   int outputs_checked   = 0;
   int replacements_seen = 0;
   int mismatch_count    = 0;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   function automatic void apply_csr(input bpfr_pkg::csr_index_type idx,
                                     input logic [63:0] data);
      case (idx)
         bpfr_pkg::CSR_FIND_LOW:         find_pat[63:0]      = data;
         bpfr_pkg::CSR_FIND_HIGH:        find_pat[127:64]    = data;
         bpfr_pkg::CSR_REPLACE_LOW:      replace_pat[63:0]   = data;
         bpfr_pkg::CSR_REPLACE_HIGH:     replace_pat[127:64] = data;
         bpfr_pkg::CSR_PATTERN_LENGTH:   pat_len             = data[4:0];
         bpfr_pkg::CSR_MAX_REPLACEMENTS: max_rep             = data[15:0];
         default: ;
      endcase
   endfunction

   function automatic void pop_window(input bit fin, input bit shortf);
      scan_out_type r;
      r.out_byte   = win_bytes[0];
      r.out_last   = fin;
      r.done       = rep_count;
      r.short_flag = shortf;
      step_out_q   = {step_out_q, r};
      for (int k = 0; k < 15; k++) win_bytes[k] = win_bytes[k + 1];
      win_fill--;
   endfunction

   function automatic void slide_window(input logic [7:0] b, input logic last);
      int len;
      bit hit;
      bit shortf;
      step_out_q.delete();
      len = int'(pat_len);
      if (len < 1) len = 1;
      if (len > bpfr_pkg::CELL_COUNT) len = bpfr_pkg::CELL_COUNT;
      if (win_fill >= 16) win_fill = 15;
      win_bytes[win_fill] = b;
      win_fill++;
      // pass the oldest surplus bytes out uncompared
      while (win_fill > len) pop_window(1'b0, 1'b0);
      if (win_fill == len) begin
         hit = 1'b1;
         for (int k = 0; k < len; k++)
            if (win_bytes[k] != find_pat[8*k +: 8]) hit = 1'b0;
         if (hit && (max_rep == 0 || rep_count < max_rep)) begin
            for (int k = 0; k < len; k++) win_bytes[k] = replace_pat[8*k +: 8];
            if (rep_count != 16'hFFFF) rep_count++;
         end
      end
      if (last) begin
         shortf = (max_rep != 0) && (rep_count < max_rep);
         while (win_fill > 0) pop_window(win_fill == 1, win_fill == 1 && shortf);
         rep_count = '0;
      end else if (win_fill == len) begin
         pop_window(1'b0, 1'b0);
      end
   endfunction

   function automatic stim_row_type csr_row(input bpfr_pkg::csr_index_type idx,
                                            input logic [63:0] data);
      stim_row_type r;
      r          = '0;
      r.kind     = ROW_CSR;
      r.csr_idx  = idx;
      r.csr_data = data;
      return r;
   endfunction

   function automatic stim_row_type byte_row(input logic [7:0] b, input logic last);
      stim_row_type r;
      r         = '0;
      r.kind    = ROW_BYTE;
      r.in_byte = b;
      r.in_last = last;
      return r;
   endfunction

   function automatic stim_row_type typed_row(input logic [7:0] b, input logic last,
                                              input logic [7:0] ob, input logic ol,
                                              input logic [15:0] done, input logic sh);
      stim_row_type r;
      r         = byte_row(b, last);
      r.kind    = ROW_TYPED;
      r.want    = '{ob, ol, done, sh};
      return r;
   endfunction

   task automatic send_item(input logic [7:0] b, input logic last, input bit typed,
                            input scan_out_type want);
      while (!steady && $urandom_range(99) < 35) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= b;
      req_if.in_last <= last;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      slide_window(b, last);
      if (typed) scan_out_q = {scan_out_q, want};
      else scan_out_q = {scan_out_q, step_out_q};
      bytes_sent++;
      if (last) regions_done++;
      if (bytes_sent == 80) hold_request = 1'b1;
      steady = (bytes_sent >= 220 && bytes_sent < 300);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (scan_out_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input bpfr_pkg::csr_index_type idx, input logic [63:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      apply_csr(idx, data);
      csr_writes++;
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_random_phase();
      logic [7:0]   sym_a, sym_b;
      logic [127:0] fpat, rpat;
      logic [63:0]  len_word;
      logic [15:0]  max_word;
      logic [7:0]   region_q [$];
      int           pick, eff, nreg, rlen, cut, n;
      bit           narrow;
      sym_a  = 8'($urandom);
      sym_b  = 8'($urandom);
      narrow = ($urandom_range(1) == 1);
      pick   = $urandom_range(99);
      if (pick < 55) len_word = 64'($urandom_range(1, 4));
      else if (pick < 85) len_word = 64'($urandom_range(5, 16));
      else if (pick < 93) len_word = 64'd0;
      else len_word = 64'($urandom_range(17, 31));
      if ($urandom_range(3) == 0) len_word = ({$urandom, $urandom} & ~64'h1F) | len_word;
      eff = int'(len_word[4:0]);
      if (eff < 1) eff = 1;
      if (eff > bpfr_pkg::CELL_COUNT) eff = bpfr_pkg::CELL_COUNT;
      for (int k = 0; k < 16; k++)
         fpat[8*k +: 8] = narrow ? ($urandom_range(1) ? sym_a : sym_b) : 8'($urandom);
      if ($urandom_range(4) == 0) rpat = fpat;
      else rpat = {$urandom, $urandom, $urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 40) max_word = '0;
      else if (pick < 80) max_word = 16'($urandom_range(1, 3));
      else if (pick < 90) max_word = 16'hFFFF;
      else max_word = 16'($urandom);

      wait_idle();
      write_csr(bpfr_pkg::CSR_FIND_LOW, fpat[63:0]);
      write_csr(bpfr_pkg::CSR_FIND_HIGH, fpat[127:64]);
      write_csr(bpfr_pkg::CSR_REPLACE_LOW, rpat[63:0]);
      write_csr(bpfr_pkg::CSR_REPLACE_HIGH, rpat[127:64]);
      write_csr(bpfr_pkg::CSR_PATTERN_LENGTH, len_word);
      write_csr(bpfr_pkg::CSR_MAX_REPLACEMENTS, {$urandom, 16'($urandom), max_word});

      nreg = $urandom_range(2, 5);
      repeat (nreg) begin
         region_q.delete();
         rlen = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 3 * eff + 8);
         while (region_q.size() < rlen) begin
            if ($urandom_range(99) < 45) begin
               n = ($urandom_range(3) == 0) ? $urandom_range(1, eff) : eff;
               for (int k = 0; k < n && region_q.size() < rlen; k++)
                  region_q = {region_q, fpat[8*k +: 8]};
            end else if (narrow && $urandom_range(99) < 70) begin
               region_q = {region_q, ($urandom_range(1) ? sym_a : sym_b)};
            end else begin
               region_q = {region_q, 8'($urandom)};
            end
         end
         cut = ($urandom_range(6) == 0 && rlen > 1) ? $urandom_range(1, rlen - 1) : 0;
         for (int k = 0; k < rlen; k++) begin
            send_item(region_q[k], k == rlen - 1, 1'b0, '0);
            // change the length inside the region
            if (k + 1 == cut) begin
               wait_idle();
               write_csr(bpfr_pkg::CSR_PATTERN_LENGTH, 64'($urandom_range(0, 31)));
            end
         end
      end
      wait_idle();
   endtask

   always @(posedge clock) begin
      scan_out_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (scan_out_q.size() == 0) begin
            report_mismatch($sformatf("extra item byte %02h last %0b",
                                      rsp_if.out_byte, rsp_if.out_last));
         end else begin
            want = scan_out_q.pop_front();
            outputs_checked++;
            if (rsp_if.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_if.out_byte, want.out_byte));
            if (rsp_if.out_last !== want.out_last)
               report_mismatch($sformatf("out_last %0b, want %0b",
                                         rsp_if.out_last, want.out_last));
            if (rsp_if.replacements_done !== want.done)
               report_mismatch($sformatf("replacements_done %0d, want %0d",
                                         rsp_if.replacements_done, want.done));
            if (rsp_if.short_of_count !== want.short_flag)
               report_mismatch($sformatf("short_of_count %0b, want %0b",
                                         rsp_if.short_of_count, want.short_flag));
            if (want.out_last) replacements_seen += want.done;
         end
      end
   end

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         // hold off long enough to back up the input
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (150) @(posedge clock);
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= 35);
      end
   end

   initial begin
      #200000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      int wait_cycles;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.in_byte = '0;
      req_if.in_last = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = bpfr_pkg::CSR_FIND_LOW;
      csr_if.data    = '0;
      find_pat       = '0;
      replace_pat    = '0;
      pat_len        = 5'd1;
      max_rep        = '0;
      win_fill       = 0;
      rep_count      = '0;
      foreach (win_bytes[i]) win_bytes[i] = '0;

      dir_rows = '{
         typed_row(8'h00, 1'b0, 8'h00, 1'b0, 16'd1, 1'b0),
         typed_row(8'hFF, 1'b1, 8'hFF, 1'b1, 16'd1, 1'b0),
         csr_row(bpfr_pkg::CSR_FIND_LOW, 64'h0123_4567_89CC_BBAA),
         csr_row(bpfr_pkg::CSR_FIND_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
         csr_row(bpfr_pkg::CSR_REPLACE_LOW, 64'hFEDC_BA98_7633_2211),
         csr_row(bpfr_pkg::CSR_REPLACE_HIGH, 64'h0000_0000_0000_0000),
         csr_row(bpfr_pkg::CSR_PATTERN_LENGTH, 64'd3),
         csr_row(bpfr_pkg::CSR_MAX_REPLACEMENTS, 64'd0),
         byte_row(8'hAA, 1'b0),
         byte_row(8'hBB, 1'b0),
         byte_row(8'hCC, 1'b0),
         byte_row(8'hAA, 1'b0),
         byte_row(8'hBB, 1'b0),
         byte_row(8'hCC, 1'b1),
         byte_row(8'h7E, 1'b0),
         byte_row(8'h81, 1'b1),
         csr_row(bpfr_pkg::CSR_MAX_REPLACEMENTS, 64'd2),
         byte_row(8'hAA, 1'b0),
         byte_row(8'hBB, 1'b0),
         byte_row(8'hCC, 1'b0),
         byte_row(8'h99, 1'b1),
         csr_row(bpfr_pkg::CSR_PATTERN_LENGTH, 64'd4),
         byte_row(8'hAA, 1'b0),
         byte_row(8'hBB, 1'b0),
         byte_row(8'hCC, 1'b0),
         csr_row(bpfr_pkg::CSR_PATTERN_LENGTH, 64'd2),
         byte_row(8'h01, 1'b1),
         csr_row(bpfr_pkg::CSR_PATTERN_LENGTH, 64'd0),
         csr_row(bpfr_pkg::CSR_MAX_REPLACEMENTS, 64'hFFFF),
         typed_row(8'hAA, 1'b0, 8'h11, 1'b0, 16'd1, 1'b0),
         typed_row(8'h00, 1'b1, 8'h00, 1'b1, 16'd1, 1'b1),
         csr_row(bpfr_pkg::CSR_PATTERN_LENGTH, 64'd31),
         byte_row(8'hFF, 1'b0),
         byte_row(8'h00, 1'b1)
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_CSR) begin
            wait_idle();
            write_csr(dir_rows[i].csr_idx, dir_rows[i].csr_data);
         end else begin
            send_item(dir_rows[i].in_byte, dir_rows[i].in_last,
                      dir_rows[i].kind == ROW_TYPED, dir_rows[i].want);
         end
      end

      while (bytes_sent < 410) run_random_phase();

      req_if.valid <= 1'b0;
      for (wait_cycles = 0; wait_cycles < 5000 && scan_out_q.size() != 0; wait_cycles++)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (scan_out_q.size() != 0)
         report_mismatch($sformatf("%0d output bytes never arrived", scan_out_q.size()));

      $display("Scanned %0d bytes in %0d regions with %0d register writes.",
               bytes_sent, regions_done, csr_writes);
      $display("Checked %0d output bytes; %0d replacements reported at region ends.",
               outputs_checked, replacements_seen);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
